### hw/rtl/ps2s2_pkg.sv
// Shared types, prefix bytes, modifier bit positions and the two translation ROMs
// for the PS/2 set 2 translator. No dependencies.
package ps2s2_pkg;

   localparam logic [7:0] BYTE_EXT     = 8'hE0;
   localparam logic [7:0] BYTE_RELEASE = 8'hF0;
   localparam logic [7:0] BYTE_PAUSE   = 8'hE1;

   localparam logic [7:0] KEY_LSHIFT = 8'h12;
   localparam logic [7:0] KEY_RSHIFT = 8'h59;
   localparam logic [7:0] KEY_CAPS   = 8'h58;
   localparam logic [7:0] KEY_CTRL   = 8'h14;
   localparam logic [7:0] KEY_ALT    = 8'h11;
   localparam logic [7:0] KEY_NUM    = 8'h77;

   localparam int unsigned MOD_NUM   = 1;
   localparam int unsigned MOD_CAPS  = 2;
   localparam int unsigned MOD_SHIFT = 3;
   localparam int unsigned MOD_CTRL  = 4;
   localparam int unsigned MOD_ALT   = 5;

   localparam logic [6:0] CODE_C     = 7'h2E;
   localparam logic [6:0] CODE_PAUSE = 7'h61;

   typedef struct packed {
      logic       valid;
      logic [6:0] key_code;
      logic       released;
      logic [7:0] modifier_flags;
      logic       break_event;
   } result_type;

   // Base translation ROM: set 2 byte to machine scan code.
   function automatic logic [6:0] base_rom(input logic [7:0] b);
      logic [6:0] c;
      case (b)
         8'h01: c = 7'h43; 8'h03: c = 7'h3f; 8'h04: c = 7'h3d; 8'h05: c = 7'h3b;
         8'h06: c = 7'h3c; 8'h07: c = 7'h58; 8'h09: c = 7'h44; 8'h0a: c = 7'h42;
         8'h0b: c = 7'h40; 8'h0c: c = 7'h3e; 8'h0d: c = 7'h0f; 8'h0e: c = 7'h29;
         8'h11: c = 7'h38; 8'h12: c = 7'h2a; 8'h14: c = 7'h1d; 8'h15: c = 7'h10;
         8'h16: c = 7'h02; 8'h1a: c = 7'h2c; 8'h1b: c = 7'h1f; 8'h1c: c = 7'h1e;
         8'h1d: c = 7'h11; 8'h1e: c = 7'h03;
         8'h21: c = 7'h2e; 8'h22: c = 7'h2d; 8'h23: c = 7'h20; 8'h24: c = 7'h12;
         8'h25: c = 7'h05; 8'h26: c = 7'h04; 8'h29: c = 7'h39; 8'h2a: c = 7'h2f;
         8'h2b: c = 7'h21; 8'h2c: c = 7'h14; 8'h2d: c = 7'h13; 8'h2e: c = 7'h06;
         8'h31: c = 7'h31; 8'h32: c = 7'h30; 8'h33: c = 7'h23; 8'h34: c = 7'h22;
         8'h35: c = 7'h15; 8'h36: c = 7'h07; 8'h3a: c = 7'h32; 8'h3b: c = 7'h24;
         8'h3c: c = 7'h16; 8'h3d: c = 7'h08; 8'h3e: c = 7'h09;
         8'h41: c = 7'h33; 8'h42: c = 7'h25; 8'h43: c = 7'h17; 8'h44: c = 7'h18;
         8'h45: c = 7'h0b; 8'h46: c = 7'h0a; 8'h49: c = 7'h34; 8'h4a: c = 7'h35;
         8'h4b: c = 7'h26; 8'h4c: c = 7'h27; 8'h4d: c = 7'h19; 8'h4e: c = 7'h0c;
         8'h52: c = 7'h28; 8'h54: c = 7'h1a; 8'h55: c = 7'h0d; 8'h58: c = 7'h3a;
         8'h59: c = 7'h36; 8'h5a: c = 7'h1c; 8'h5b: c = 7'h1b; 8'h5d: c = 7'h2b;
         8'h66: c = 7'h0e; 8'h69: c = 7'h4f;
         8'h70: c = 7'h52; 8'h71: c = 7'h53; 8'h72: c = 7'h50; 8'h73: c = 7'h4c;
         8'h74: c = 7'h4d; 8'h75: c = 7'h48; 8'h76: c = 7'h01; 8'h77: c = 7'h45;
         8'h78: c = 7'h57; 8'h79: c = 7'h4e;
         8'h83: c = 7'h41;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   // Extended translation ROM, used for keys that follow an E0 prefix.
   function automatic logic [6:0] ext_rom(input logic [7:0] b);
      logic [6:0] c;
      case (b)
         8'h11: c = 7'h5c; 8'h14: c = 7'h5e; 8'h1f: c = 7'h5b; 8'h27: c = 7'h5b;
         8'h2f: c = 7'h5d; 8'h4a: c = 7'h6c; 8'h5a: c = 7'h6d; 8'h69: c = 7'h66;
         8'h6b: c = 7'h69; 8'h6c: c = 7'h63; 8'h70: c = 7'h62; 8'h71: c = 7'h65;
         8'h72: c = 7'h6a; 8'h74: c = 7'h6b; 8'h75: c = 7'h68; 8'h7a: c = 7'h67;
         8'h7d: c = 7'h64;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/ps2s2_decoder.sv
// Prefix and Pause sequence tracker, modifier flags and ROM lookup for one byte.
// Depends on ps2s2_pkg.
module ps2s2_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             ps2_byte,
   output ps2s2_pkg::result_type  result
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'd0,
      ST_E0   = 4'd1,
      ST_E0F0 = 4'd2,
      ST_F0   = 4'd3,
      ST_P1   = 4'd4,
      ST_P2   = 4'd5,
      ST_P3   = 4'd6,
      ST_P4   = 4'd7,
      ST_P5   = 4'd8,
      ST_P6   = 4'd9,
      ST_P7   = 4'd10
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] mods_ff, mods_in;

   logic       key_hit;
   logic       use_ext;
   logic       press;
   logic       pause_done;
   logic [6:0] code;

   always_comb begin
      state_in   = state_ff;
      key_hit    = 1'b0;
      use_ext    = 1'b0;
      press      = 1'b1;
      pause_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (ps2_byte == ps2s2_pkg::BYTE_EXT) begin
               state_in = ST_E0;
            end else if (ps2_byte == ps2s2_pkg::BYTE_RELEASE) begin
               state_in = ST_F0;
            end else if (ps2_byte == ps2s2_pkg::BYTE_PAUSE) begin
               state_in = ST_P1;
            end else begin
               key_hit = 1'b1;
            end
         end
         ST_E0: begin
            if (ps2_byte == ps2s2_pkg::BYTE_RELEASE) begin
               state_in = ST_E0F0;
            end else begin
               key_hit  = 1'b1;
               use_ext  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_F0: begin
            key_hit  = 1'b1;
            press    = 1'b0;
            state_in = ST_IDLE;
         end
         ST_E0F0: begin
            key_hit  = 1'b1;
            use_ext  = 1'b1;
            press    = 1'b0;
            state_in = ST_IDLE;
         end
         // The Pause sequence runs E1 14 77 E1 F0 14 F0 77; any mismatch drops to idle.
         ST_P1: state_in = (ps2_byte == ps2s2_pkg::KEY_CTRL) ? ST_P2 : ST_IDLE;
         ST_P2: state_in = (ps2_byte == ps2s2_pkg::KEY_NUM) ? ST_P3 : ST_IDLE;
         ST_P3: state_in = (ps2_byte == ps2s2_pkg::BYTE_PAUSE) ? ST_P4 : ST_IDLE;
         ST_P4: state_in = (ps2_byte == ps2s2_pkg::BYTE_RELEASE) ? ST_P5 : ST_IDLE;
         ST_P5: state_in = (ps2_byte == ps2s2_pkg::KEY_CTRL) ? ST_P6 : ST_IDLE;
         ST_P6: state_in = (ps2_byte == ps2s2_pkg::BYTE_RELEASE) ? ST_P7 : ST_IDLE;
         ST_P7: begin
            pause_done = (ps2_byte == ps2s2_pkg::KEY_NUM);
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Held modifiers follow press and release; the locks toggle on release only.
   always_comb begin
      mods_in = mods_ff;
      if (key_hit) begin
         if (use_ext) begin
            case (ps2_byte)
               ps2s2_pkg::KEY_CTRL: mods_in[ps2s2_pkg::MOD_CTRL] = press;
               ps2s2_pkg::KEY_ALT:  mods_in[ps2s2_pkg::MOD_ALT]  = press;
               default: ;
            endcase
         end else begin
            case (ps2_byte)
               ps2s2_pkg::KEY_LSHIFT, ps2s2_pkg::KEY_RSHIFT:
                  mods_in[ps2s2_pkg::MOD_SHIFT] = press;
               ps2s2_pkg::KEY_CTRL: mods_in[ps2s2_pkg::MOD_CTRL] = press;
               ps2s2_pkg::KEY_ALT:  mods_in[ps2s2_pkg::MOD_ALT]  = press;
               ps2s2_pkg::KEY_CAPS:
                  mods_in[ps2s2_pkg::MOD_CAPS] = mods_ff[ps2s2_pkg::MOD_CAPS] ^ !press;
               ps2s2_pkg::KEY_NUM:
                  mods_in[ps2s2_pkg::MOD_NUM] = mods_ff[ps2s2_pkg::MOD_NUM] ^ !press;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (pause_done) begin
         code = ps2s2_pkg::CODE_PAUSE;
      end else if (use_ext) begin
         code = ps2s2_pkg::ext_rom(ps2_byte);
      end else begin
         code = ps2s2_pkg::base_rom(ps2_byte);
      end
      result.valid          = (key_hit || pause_done) && (code != 7'h00);
      result.key_code       = code;
      result.released       = !press;
      result.modifier_flags = mods_in;
      if (!press) begin
         result.break_event = 1'b0;
      end else if (mods_in[ps2s2_pkg::MOD_CTRL]) begin
         result.break_event = (code == ps2s2_pkg::CODE_C);
      end else begin
         result.break_event = mods_in[ps2s2_pkg::MOD_ALT] && (code == ps2s2_pkg::CODE_PAUSE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mods_ff  <= 8'h00;
      end else if (step) begin
         state_ff <= state_in;
         mods_ff  <= mods_in;
      end
   end

endmodule

### hw/rtl/ps2s2_set2_scancode_translator.sv
// Top level of the PS/2 set 2 to machine scan code translator.
// Depends on ps2s2_pkg and ps2s2_decoder.
//
//   Channel | Direction | Payload
//   --------+-----------+-------------------------------------------------------
//   req_    | in        | tdata[7:0] raw set 2 byte
//   rsp_    | out       | tdata[6:0] key_code, [7] released, [15:8] modifier_flags,
//           |           | [16] break_event, [23:17] zero
//
// Each byte passes from its transfer in through the input register, then through the
// decoder into the result register. One byte is taken every cycle while the result
// is not stalled; the decoder state loop closes through the decoder state register.
// Reset is synchronous and clears the decoder state, the modifier flags and both
// valid bits. A stalled result holds both stages; the input register still takes
// a byte when it is empty or moving forward.
module ps2_set2_scancode_translator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ps2_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [6:0] key_code, [7] released,
                                    // [15:8] modifier_flags, [16] break_event
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  rsp_valid_ff;
   ps2s2_pkg::result_type rsp_data_ff;

   logic                  advance;
   logic                  step;
   ps2s2_pkg::result_type result;

   // The result register can load whenever it is empty or being drained this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   ps2s2_decoder u_decoder (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .ps2_byte (in_byte_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= step && result.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.break_event, rsp_data_ff.modifier_flags,
                        rsp_data_ff.released, rsp_data_ff.key_code};

endmodule
